### hw/rtl/ffpa_pkg.sv
// shared types, codes and helpers for the first-fit partition allocator
package ffpa_pkg;

    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 10;
    localparam int SIZE_W   = 10;
    localparam int STATUS_W = 2;

    typedef logic [DATA_W-1:0] word_t;

    // action codes
    localparam logic ACT_ALLOC   = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_NOFIT = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_SELECT,
        S_UPDATE
    } state_t;

    // which cells compete for the target slot
    typedef enum logic [2:0] {
        SEL_NONE,
        SEL_FIT,
        SEL_HEAD,
        SEL_LAST,
        SEL_APPEND,
        SEL_PAIR
    } sel_t;

    // table update applied around the target cell
    typedef enum logic [2:0] {
        OP_NONE,
        OP_ALLOC,
        OP_GROW_FRONT,
        OP_GROW_BACK,
        OP_GROW_BACK_DN,
        OP_JOIN,
        OP_INSERT
    } op_t;

    typedef struct packed {
        logic              eval;
        logic              select;
        sel_t              sel;
        op_t               op;
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W:0]   limit;
    } cell_cmd_t;

    typedef struct packed {
        logic  valid;
        word_t start;
        word_t len;
        logic  lt;
        logic  lo_adj;
        logic  self_end;
        logic  pair;
        logic  is_last;
        logic  tgt;
    } cell_view_t;

    typedef struct packed {
        logic              head_lt;
        logic              head_self_end;
        logic              last_lt;
        logic              last_lo_adj;
        logic              hit;
        logic              tgt_lo_dn;
        logic              tgt_self_end;
        logic [ADDR_W-1:0] tgt_start;
    } table_sum_t;

    function automatic word_t sat_add(input word_t a, input word_t b);
        logic [DATA_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[DATA_W] ? '1 : s[DATA_W-1:0];
    endfunction

endpackage

### hw/rtl/first_fit_partition_allocator_core.sv
// top level of the first-fit partition allocator: cell row plus sequencer
//
// usage
//   request channel (req_valid / req_stall): action 0 allocates block_size
//   units, action 1 releases block_size units starting at block_address
//   result channel (rsp_valid / rsp_stall): one transfer per request with
//   granted_address (start of an allocated block, else zero) and status
//   (0 ok, 1 nothing large enough, 2 free table full)
//   the free table is a row of TABLE_ENTRIES cells kept in address order;
//   each request runs evaluate, select and update steps over the whole row
//   the result register loads in the update step, after the evaluate and select
//   steps; a new request is taken only back in idle, so requests do not overlap:
//   accept, evaluate, select and update run in turn, and the target-priority ripple
//   through the cells settles within the select cycle
//   reset: one free entry from RESERVED_BASE to MEMORY_SIZE, entry count one
//   a stalled result holds; a request that finishes while the previous result
//   is still stalled waits in its update step until the result register frees
module first_fit_partition_allocator_core #(
    parameter int TABLE_ENTRIES = 16,
    parameter int MEMORY_SIZE   = 1000,
    parameter int RESERVED_BASE = 100
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic                          action,
    input  logic [ffpa_pkg::SIZE_W-1:0]   block_size,
    input  logic [ffpa_pkg::ADDR_W-1:0]   block_address,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [ffpa_pkg::ADDR_W-1:0]   granted_address,
    output logic [ffpa_pkg::STATUS_W-1:0] status
);

    // initial free entry above the reserved area
    localparam ffpa_pkg::word_t INIT_START = ffpa_pkg::DATA_W'(RESERVED_BASE);
    localparam ffpa_pkg::word_t INIT_LEN   = (MEMORY_SIZE > RESERVED_BASE) ?
        ffpa_pkg::DATA_W'(MEMORY_SIZE - RESERVED_BASE) : '0;

    ffpa_pkg::cell_cmd_t  cmd;
    ffpa_pkg::table_sum_t sum;
    ffpa_pkg::cell_view_t view [TABLE_ENTRIES];
    ffpa_pkg::cell_view_t dn_view [TABLE_ENTRIES];
    ffpa_pkg::cell_view_t up_view [TABLE_ENTRIES];
    logic [TABLE_ENTRIES:0]   prior;
    logic [TABLE_ENTRIES-1:0] valid_vec;
    logic [TABLE_ENTRIES-1:0] tgt_vec;

    // priority ripple starts clear at the head of the row
    assign prior[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < TABLE_ENTRIES; g++)
        begin : g_cell
            // row ends see an empty neighbor
            if (g == 0)
            begin : g_head
                assign dn_view[g] = '0;
            end
            else
            begin : g_body
                assign dn_view[g] = view[g-1];
            end
            if (g == TABLE_ENTRIES - 1)
            begin : g_top
                assign up_view[g] = '0;
            end
            else
            begin : g_mid
                assign up_view[g] = view[g+1];
            end

            ffpa_cell #(
                .IS_HEAD     (g == 0),
                .RESET_VALID (g == 0),
                .RESET_START ((g == 0) ? INIT_START : '0),
                .RESET_LEN   ((g == 0) ? INIT_LEN : '0)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cmd),
                .dn        (dn_view[g]),
                .up        (up_view[g]),
                .prior_in  (prior[g]),
                .prior_out (prior[g+1]),
                .view      (view[g])
            );

            assign valid_vec[g] = view[g].valid;
            assign tgt_vec[g]   = view[g].tgt;
        end
    endgenerate

    // row summaries for the sequencer
    always_comb
    begin
        sum               = '0;
        sum.head_lt       = view[0].lt;
        sum.head_self_end = view[0].self_end;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            sum.last_lt      = sum.last_lt      | (view[i].is_last & view[i].lt);
            sum.last_lo_adj  = sum.last_lo_adj  | (view[i].is_last & view[i].lo_adj);
            sum.hit          = sum.hit          | view[i].tgt;
            sum.tgt_self_end = sum.tgt_self_end | (view[i].tgt & view[i].self_end);
            sum.tgt_start    = sum.tgt_start |
                (view[i].tgt ? view[i].start[ffpa_pkg::ADDR_W-1:0] : '0);
        end
        for (int i = 1; i < TABLE_ENTRIES; i++)
        begin
            sum.tgt_lo_dn = sum.tgt_lo_dn | (view[i].tgt & view[i-1].lo_adj);
        end
    end

    ffpa_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .action          (action),
        .block_size      (block_size),
        .block_address   (block_address),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .granted_address (granted_address),
        .status          (status),
        .sum             (sum),
        .cmd             (cmd)
    );

`ifndef SYNTHESIS
    a_one_target: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tgt_vec))
        else $error("more than one target cell");

    a_valid_packed: assert property (@(posedge clk) disable iff (!rst_n)
        ((valid_vec + TABLE_ENTRIES'(1)) & valid_vec) == '0)
        else $error("free entries not packed at the head of the row");

    a_hit_from_ripple: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.select |=> (sum.hit == $past(prior[TABLE_ENTRIES])))
        else $error("target flags disagree with the priority ripple");
`endif

endmodule

### hw/rtl/ffpa_cell.sv
// one free-table entry with its compare flags and neighbor shift paths
module ffpa_cell #(
    parameter bit             IS_HEAD     = 1'b0,
    parameter bit             RESET_VALID = 1'b0,
    parameter ffpa_pkg::word_t RESET_START = '0,
    parameter ffpa_pkg::word_t RESET_LEN   = '0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ffpa_pkg::cell_cmd_t  cmd,
    input  ffpa_pkg::cell_view_t dn,
    input  ffpa_pkg::cell_view_t up,
    input  logic                 prior_in,
    output logic                 prior_out,
    output ffpa_pkg::cell_view_t view
);

    logic            valid_reg, valid_next;
    ffpa_pkg::word_t start_reg, start_next;
    ffpa_pkg::word_t len_reg, len_next;
    logic            fit_reg, fit_next;
    logic            lt_reg, lt_next;
    logic            lo_adj_reg, lo_adj_next;
    logic            self_end_reg, self_end_next;
    logic            pair_reg, pair_next;
    logic            is_last_reg, is_last_next;
    logic            tgt_reg, tgt_next;
    logic            after_reg, after_next;
    logic            match;
    ffpa_pkg::word_t size_w;
    ffpa_pkg::word_t addr_w;
    ffpa_pkg::word_t grown;

    assign size_w = ffpa_pkg::DATA_W'(cmd.size);
    assign addr_w = ffpa_pkg::DATA_W'(cmd.addr);
    assign grown  = ffpa_pkg::sat_add(len_reg, size_w);

    always_comb
    begin
        unique case (cmd.sel)
            ffpa_pkg::SEL_NONE:   match = 1'b0;
            ffpa_pkg::SEL_FIT:    match = fit_reg;
            ffpa_pkg::SEL_HEAD:   match = IS_HEAD;
            ffpa_pkg::SEL_LAST:   match = is_last_reg;
            ffpa_pkg::SEL_APPEND: match = !valid_reg;
            ffpa_pkg::SEL_PAIR:   match = dn.pair;
            default:              match = 1'b0;
        endcase
    end

    assign prior_out = prior_in | match;

    always_comb
    begin
        valid_next    = valid_reg;
        start_next    = start_reg;
        len_next      = len_reg;
        fit_next      = fit_reg;
        lt_next       = lt_reg;
        lo_adj_next   = lo_adj_reg;
        self_end_next = self_end_reg;
        pair_next     = pair_reg;
        is_last_next  = is_last_reg;
        tgt_next      = tgt_reg;
        after_next    = after_reg;

        if (cmd.eval)
        begin
            fit_next      = valid_reg && (len_reg >= size_w);
            lt_next       = valid_reg && (start_reg < addr_w);
            lo_adj_next   = valid_reg && (ffpa_pkg::sat_add(start_reg, len_reg) == addr_w);
            self_end_next = valid_reg && (start_reg == ffpa_pkg::DATA_W'(cmd.limit));
            pair_next     = valid_reg && up.valid && (start_reg < addr_w) && (up.start > addr_w);
            is_last_next  = valid_reg && !up.valid;
        end

        if (cmd.select)
        begin
            tgt_next   = match && !prior_in;
            after_next = prior_in;
        end

        unique case (cmd.op)
            ffpa_pkg::OP_NONE:
            begin
            end
            ffpa_pkg::OP_ALLOC:
            begin
                if (tgt_reg)
                begin
                    len_next   = len_reg - size_w;
                    start_next = ffpa_pkg::sat_add(start_reg, size_w);
                end
            end
            ffpa_pkg::OP_GROW_FRONT:
            begin
                if (tgt_reg)
                begin
                    start_next = addr_w;
                    len_next   = grown;
                end
            end
            ffpa_pkg::OP_GROW_BACK:
            begin
                if (tgt_reg)
                begin
                    len_next = grown;
                end
            end
            ffpa_pkg::OP_GROW_BACK_DN:
            begin
                if (up.tgt)
                begin
                    len_next = grown;
                end
            end
            ffpa_pkg::OP_JOIN:
            begin
                // the entry below the target absorbs it, the rest slide down
                priority if (up.tgt)
                begin
                    len_next = ffpa_pkg::sat_add(grown, up.len);
                end
                else if (tgt_reg || after_reg)
                begin
                    valid_next = up.valid;
                    start_next = up.start;
                    len_next   = up.len;
                end
                else
                begin
                    // entries further down keep their contents
                end
            end
            ffpa_pkg::OP_INSERT:
            begin
                priority if (tgt_reg)
                begin
                    valid_next = 1'b1;
                    start_next = addr_w;
                    len_next   = size_w;
                end
                else if (after_reg)
                begin
                    valid_next = dn.valid;
                    start_next = dn.start;
                    len_next   = dn.len;
                end
                else
                begin
                    // entries below the insertion point keep their contents
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= RESET_VALID;
            start_reg    <= RESET_START;
            len_reg      <= RESET_LEN;
            fit_reg      <= 1'b0;
            lt_reg       <= 1'b0;
            lo_adj_reg   <= 1'b0;
            self_end_reg <= 1'b0;
            pair_reg     <= 1'b0;
            is_last_reg  <= 1'b0;
            tgt_reg      <= 1'b0;
            after_reg    <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            start_reg    <= start_next;
            len_reg      <= len_next;
            fit_reg      <= fit_next;
            lt_reg       <= lt_next;
            lo_adj_reg   <= lo_adj_next;
            self_end_reg <= self_end_next;
            pair_reg     <= pair_next;
            is_last_reg  <= is_last_next;
            tgt_reg      <= tgt_next;
            after_reg    <= after_next;
        end
    end

    always_comb
    begin
        view          = '0;
        view.valid    = valid_reg;
        view.start    = start_reg;
        view.len      = len_reg;
        view.lt       = lt_reg;
        view.lo_adj   = lo_adj_reg;
        view.self_end = self_end_reg;
        view.pair     = pair_reg;
        view.is_last  = is_last_reg;
        view.tgt      = tgt_reg;
    end

endmodule

### hw/rtl/ffpa_ctrl.sv
// request sequencer, entry count and result register of the allocator
module ffpa_ctrl #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  logic                              action,
    input  logic [ffpa_pkg::SIZE_W-1:0]       block_size,
    input  logic [ffpa_pkg::ADDR_W-1:0]       block_address,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output logic [ffpa_pkg::ADDR_W-1:0]       granted_address,
    output logic [ffpa_pkg::STATUS_W-1:0]     status,
    input  ffpa_pkg::table_sum_t              sum,
    output ffpa_pkg::cell_cmd_t               cmd
);

    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [2:0] {
        PLAN_ALLOC,
        PLAN_INSERT,
        PLAN_FRONT,
        PLAN_BACK,
        PLAN_PAIR
    } plan_t;

    ffpa_pkg::state_t              state_reg, state_next;
    plan_t                         plan_reg, plan_next;
    logic                          action_reg, action_next;
    logic [ffpa_pkg::SIZE_W-1:0]   size_reg, size_next;
    logic [ffpa_pkg::ADDR_W-1:0]   addr_reg, addr_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic                          rsp_valid_reg, rsp_valid_next;
    logic [ffpa_pkg::ADDR_W-1:0]   granted_reg, granted_next;
    ffpa_pkg::status_t             status_reg, status_next;
    ffpa_pkg::sel_t                sel;
    ffpa_pkg::op_t                 op;
    logic                          table_empty;
    logic                          table_full;
    logic                          rsp_free;

    assign table_empty = (count_reg == '0);
    assign table_full  = (count_reg == CNT_W'(TABLE_ENTRIES));
    assign rsp_free    = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next     = state_reg;
        plan_next      = plan_reg;
        action_next    = action_reg;
        size_next      = size_reg;
        addr_next      = addr_reg;
        count_next     = count_reg;
        granted_next   = granted_reg;
        status_next    = status_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        sel            = ffpa_pkg::SEL_NONE;
        op             = ffpa_pkg::OP_NONE;

        unique case (state_reg)
            ffpa_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    action_next = action;
                    size_next   = block_size;
                    addr_next   = block_address;
                    state_next  = ffpa_pkg::S_EVAL;
                end
            end
            ffpa_pkg::S_EVAL:
            begin
                state_next = ffpa_pkg::S_SELECT;
            end
            ffpa_pkg::S_SELECT:
            begin
                // pick the plan: first fit for an allocate, else the release case from the head and last entry flags
                priority if (action_reg == ffpa_pkg::ACT_ALLOC)
                begin
                    plan_next = PLAN_ALLOC;
                    sel       = ffpa_pkg::SEL_FIT;
                end
                else if (table_empty || !sum.head_lt)
                begin
                    plan_next = (!table_empty && sum.head_self_end) ? PLAN_FRONT : PLAN_INSERT;
                    sel       = ffpa_pkg::SEL_HEAD;
                end
                else if (sum.last_lt)
                begin
                    plan_next = sum.last_lo_adj ? PLAN_BACK : PLAN_INSERT;
                    sel       = sum.last_lo_adj ? ffpa_pkg::SEL_LAST : ffpa_pkg::SEL_APPEND;
                end
                else
                begin
                    plan_next = PLAN_PAIR;
                    sel       = ffpa_pkg::SEL_PAIR;
                end
                state_next = ffpa_pkg::S_UPDATE;
            end
            ffpa_pkg::S_UPDATE:
            begin
                if (rsp_free)
                begin
                    state_next     = ffpa_pkg::S_IDLE;
                    rsp_valid_next = 1'b1;
                    granted_next   = '0;
                    status_next    = ffpa_pkg::ST_OK;
                    unique case (plan_reg)
                        PLAN_ALLOC:
                        begin
                            if (sum.hit)
                            begin
                                op           = ffpa_pkg::OP_ALLOC;
                                granted_next = sum.tgt_start;
                            end
                            else
                            begin
                                status_next = ffpa_pkg::ST_NOFIT;
                            end
                        end
                        PLAN_INSERT:
                        begin
                            if (table_full)
                            begin
                                status_next = ffpa_pkg::ST_FULL;
                            end
                            else
                            begin
                                op         = ffpa_pkg::OP_INSERT;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        PLAN_FRONT:
                        begin
                            op = ffpa_pkg::OP_GROW_FRONT;
                        end
                        PLAN_BACK:
                        begin
                            op = ffpa_pkg::OP_GROW_BACK;
                        end
                        PLAN_PAIR:
                        begin
                            priority if (!sum.hit)
                            begin
                                op = ffpa_pkg::OP_NONE;
                            end
                            else if (sum.tgt_lo_dn && sum.tgt_self_end)
                            begin
                                op         = ffpa_pkg::OP_JOIN;
                                count_next = count_reg - CNT_W'(1);
                            end
                            else if (sum.tgt_lo_dn)
                            begin
                                op = ffpa_pkg::OP_GROW_BACK_DN;
                            end
                            else if (sum.tgt_self_end)
                            begin
                                op = ffpa_pkg::OP_GROW_FRONT;
                            end
                            else if (table_full)
                            begin
                                status_next = ffpa_pkg::ST_FULL;
                            end
                            else
                            begin
                                op         = ffpa_pkg::OP_INSERT;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ffpa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ffpa_pkg::S_IDLE;
            plan_reg      <= PLAN_ALLOC;
            count_reg     <= CNT_W'(1);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            plan_reg      <= plan_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg  <= action_next;
        size_reg    <= size_next;
        addr_reg    <= addr_next;
        granted_reg <= granted_next;
        status_reg  <= status_next;
    end

    always_comb
    begin
        cmd        = '0;
        cmd.eval   = (state_reg == ffpa_pkg::S_EVAL);
        cmd.select = (state_reg == ffpa_pkg::S_SELECT);
        cmd.sel    = sel;
        cmd.op     = op;
        cmd.addr   = addr_reg;
        cmd.size   = size_reg;
        cmd.limit  = {1'b0, addr_reg} + {1'b0, size_reg};
    end

    assign req_stall       = (state_reg != ffpa_pkg::S_IDLE);
    assign rsp_valid       = rsp_valid_reg;
    assign granted_address = granted_reg;
    assign status          = status_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_ENTRIES))
        else $error("entry count beyond table size");

    a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> state_reg == ffpa_pkg::S_EVAL)
        else $error("accepted request did not start evaluation");

    a_rsp_from_update: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ffpa_pkg::S_UPDATE))
        else $error("result loaded outside the update step");
`endif

endmodule

### bench/free_table_checker.sv
// checker for the first-fit allocator: shadow free table, expected results and comparison
`timescale 1ns / 100ps
module free_table_checker #(
    parameter int TABLE_ENTRIES = 16,
    parameter int MEMORY_SIZE   = 1000,
    parameter int RESERVED_BASE = 100
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  logic                          req_stall,
    input  logic                          action,
    input  logic [ffpa_pkg::SIZE_W-1:0]   block_size,
    input  logic [ffpa_pkg::ADDR_W-1:0]   block_address,
    input  logic                          rsp_valid,
    input  logic                          rsp_stall,
    input  logic [ffpa_pkg::ADDR_W-1:0]   granted_address,
    input  logic [ffpa_pkg::STATUS_W-1:0] status,
    output int                            mismatches,
    output int                            owed
);

    typedef struct {
        logic [ffpa_pkg::ADDR_W-1:0] grant;
        ffpa_pkg::status_t           code;
    } outcome_t;

    // shadow free table, kept in address order
    ffpa_pkg::word_t part_start [TABLE_ENTRIES];
    ffpa_pkg::word_t part_len   [TABLE_ENTRIES];
    int unsigned     part_count;

    outcome_t due_results[$];
    int       fail_tally = 0;

    function automatic ffpa_pkg::word_t add_clamped(input ffpa_pkg::word_t a,
                                                    input ffpa_pkg::word_t b);
        ffpa_pkg::word_t s;
        s = a + b;
        return (s < a) ? '1 : s;
    endfunction

    function automatic void clear_table();
        for (int k = 0; k < TABLE_ENTRIES; k++)
        begin
            part_start[k] = '0;
            part_len[k]   = '0;
        end
        part_start[0] = RESERVED_BASE;
        part_len[0]   = (MEMORY_SIZE > RESERVED_BASE) ? MEMORY_SIZE - RESERVED_BASE : 0;
        part_count    = 1;
    endfunction

    // open a slot at pos and shift the tail up; refused when the table is full or pos is past the end
    function automatic bit open_slot(input int unsigned pos, input ffpa_pkg::word_t start,
                                     input ffpa_pkg::word_t len);
        if (part_count >= TABLE_ENTRIES || pos > part_count)
            return 1'b0;
        for (int unsigned k = part_count; k > pos; k--)
        begin
            part_start[k] = part_start[k-1];
            part_len[k]   = part_len[k-1];
        end
        part_start[pos] = start;
        part_len[pos]   = len;
        part_count++;
        return 1'b1;
    endfunction

    function automatic void close_slot(input int unsigned pos);
        if (pos >= part_count)
            return;
        for (int unsigned k = pos; k + 1 < part_count; k++)
        begin
            part_start[k] = part_start[k+1];
            part_len[k]   = part_len[k+1];
        end
        part_count--;
    endfunction

    // first fit: shrink the first large enough entry from the front
    function automatic outcome_t carve(input ffpa_pkg::word_t size);
        outcome_t res;
        bit       found;
        res.grant = '0;
        res.code  = ffpa_pkg::ST_NOFIT;
        found     = 1'b0;
        for (int unsigned i = 0; i < part_count; i++)
        begin
            if (!found && part_len[i] >= size)
            begin
                res.grant     = part_start[i][ffpa_pkg::ADDR_W-1:0];
                part_len[i]   = part_len[i] - size;
                part_start[i] = add_clamped(part_start[i], size);
                res.code      = ffpa_pkg::ST_OK;
                found         = 1'b1;
            end
        end
        return res;
    endfunction

    // return a block: coalesce with neighbors, else insert in order
    function automatic ffpa_pkg::status_t give_back(input ffpa_pkg::word_t addr,
                                                    input ffpa_pkg::word_t size);
        ffpa_pkg::word_t blk_end;
        int unsigned     last;
        bit              lo;
        bit              hi;
        blk_end = addr + size;
        if (part_count == 0)
            return open_slot(0, addr, size) ? ffpa_pkg::ST_OK : ffpa_pkg::ST_FULL;
        if (part_start[0] >= addr)
        begin
            if (part_start[0] == blk_end)
            begin
                part_start[0] = addr;
                part_len[0]   = add_clamped(part_len[0], size);
                return ffpa_pkg::ST_OK;
            end
            return open_slot(0, addr, size) ? ffpa_pkg::ST_OK : ffpa_pkg::ST_FULL;
        end
        last = part_count - 1;
        if (part_start[last] < addr)
        begin
            if (add_clamped(part_start[last], part_len[last]) == addr)
            begin
                part_len[last] = add_clamped(part_len[last], size);
                return ffpa_pkg::ST_OK;
            end
            return open_slot(part_count, addr, size) ? ffpa_pkg::ST_OK : ffpa_pkg::ST_FULL;
        end
        for (int unsigned i = 0; i + 1 < part_count; i++)
        begin
            if (part_start[i] < addr && part_start[i+1] > addr)
            begin
                lo = (add_clamped(part_start[i], part_len[i]) == addr);
                hi = (part_start[i+1] == blk_end);
                if (lo && hi)
                begin
                    part_len[i] = add_clamped(add_clamped(part_len[i], size), part_len[i+1]);
                    close_slot(i + 1);
                end
                else if (lo)
                begin
                    part_len[i] = add_clamped(part_len[i], size);
                end
                else if (hi)
                begin
                    part_start[i+1] = addr;
                    part_len[i+1]   = add_clamped(part_len[i+1], size);
                end
                else
                begin
                    return open_slot(i + 1, addr, size) ? ffpa_pkg::ST_OK : ffpa_pkg::ST_FULL;
                end
                return ffpa_pkg::ST_OK;
            end
        end
        // address equal to the start of an inner entry: nothing changes
        return ffpa_pkg::ST_OK;
    endfunction

    always @(posedge clk)
    begin : watch
        outcome_t want;
        if (!rst_n)
        begin
            clear_table();
            due_results.delete();
        end
        else
        begin
            // results first, so a same-edge request never pairs with this result
            if (rsp_valid && !rsp_stall)
            begin
                if (due_results.size() == 0)
                begin
                    $error("stray result transfer: granted_address %0d status %0d",
                           granted_address, status);
                    fail_tally++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (granted_address !== want.grant)
                    begin
                        $error("granted_address: expected %0d, actual %0d",
                               want.grant, granted_address);
                        fail_tally++;
                    end
                    if (status !== want.code)
                    begin
                        $error("status: expected %0d, actual %0d", want.code, status);
                        fail_tally++;
                    end
                end
            end
            if (req_valid && !req_stall)
            begin
                if (action == ffpa_pkg::ACT_ALLOC)
                begin
                    want = carve(ffpa_pkg::word_t'(block_size));
                end
                else
                begin
                    want.grant = '0;
                    want.code  = give_back(ffpa_pkg::word_t'(block_address),
                                           ffpa_pkg::word_t'(block_size));
                end
                due_results.insert(due_results.size(), want);
            end
        end
        mismatches <= fail_tally;
        owed       <= due_results.size();
    end

endmodule

### bench/tb_first_fit_partition_allocator_core.sv
// testbench top for the first-fit allocator: clock, reset, stimulus, result stalls, verdict
`timescale 1ns / 100ps
module tb_first_fit_partition_allocator_core;

    localparam int TABLE_ENTRIES = 16;
    localparam int MEMORY_SIZE   = 1000;
    localparam int RESERVED_BASE = 100;
    localparam int PHASE_ITEMS   = 600;   // three idle mixes, about 1800 random requests
    localparam int DRAIN_CYCLES  = 16;    // idle wait after the drain so stray result transfers can show

    // a block this bench holds after a successful allocate, released later
    typedef struct {
        logic [ffpa_pkg::ADDR_W-1:0] addr;
        logic [ffpa_pkg::SIZE_W-1:0] size;
    } block_t;

    // what was asked, so the result can be tied back to it
    typedef struct {
        logic                        act;
        logic [ffpa_pkg::SIZE_W-1:0] size;
    } asked_t;

    logic                          clk           = 1'b0;
    logic                          rst_n         = 1'b0;
    logic                          req_valid     = 1'b0;
    logic                          action        = ffpa_pkg::ACT_ALLOC;
    logic [ffpa_pkg::SIZE_W-1:0]   block_size    = '0;
    logic [ffpa_pkg::ADDR_W-1:0]   block_address = '0;
    logic                          rsp_stall     = 1'b0;
    logic                          req_stall;
    logic                          rsp_valid;
    logic [ffpa_pkg::ADDR_W-1:0]   granted_address;
    logic [ffpa_pkg::STATUS_W-1:0] status;

    int mismatches;
    int owed;

    // idle mix, percent per cycle
    int send_gap_pct = 8;
    int stall_pct    = 87;

    block_t held_blocks[$];
    asked_t in_flight[$];

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    first_fit_partition_allocator_core #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MEMORY_SIZE   (MEMORY_SIZE),
        .RESERVED_BASE (RESERVED_BASE)
    ) u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .action          (action),
        .block_size      (block_size),
        .block_address   (block_address),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .granted_address (granted_address),
        .status          (status)
    );

    free_table_checker #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MEMORY_SIZE   (MEMORY_SIZE),
        .RESERVED_BASE (RESERVED_BASE)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .action          (action),
        .block_size      (block_size),
        .block_address   (block_address),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .granted_address (granted_address),
        .status          (status),
        .mismatches      (mismatches),
        .owed            (owed)
    );

    // result side: stall drawn fresh every cycle from the current mix
    always @(posedge clk)
    begin
        rsp_stall <= ($urandom_range(99) < stall_pct);
    end

    // remember granted blocks so later releases give back real allocations
    always @(posedge clk)
    begin : track_grants
        asked_t done;
        block_t got;
        if (rst_n && rsp_valid && !rsp_stall && in_flight.size() != 0)
        begin
            done = in_flight.pop_front();
            if (done.act == ffpa_pkg::ACT_ALLOC && status == ffpa_pkg::ST_OK && done.size != 0)
            begin
                got.addr = granted_address;
                got.size = done.size;
                held_blocks.insert(held_blocks.size(), got);
            end
        end
    end

    // one request transfer; random idle cycles in front, payload held while stalled
    task automatic send(input logic act, input logic [ffpa_pkg::SIZE_W-1:0] sz,
                        input logic [ffpa_pkg::ADDR_W-1:0] ad);
        asked_t item;
        while ($urandom_range(99) < send_gap_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid     <= 1'b1;
        action        <= act;
        block_size    <= sz;
        block_address <= ad;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        item.act  = act;
        item.size = sz;
        in_flight.insert(in_flight.size(), item);
    endtask

    // mostly well-formed traffic: allocate small blocks and hand back held ones;
    // the rest is noise that overlaps, lands anywhere or asks for zero
    task automatic send_random();
        int                          pick;
        int                          idx;
        block_t                      blk;
        logic [ffpa_pkg::SIZE_W-1:0] sz;
        pick = $urandom_range(99);
        if (pick >= 45 && pick < 85 && held_blocks.size() != 0)
        begin
            idx = $urandom_range(held_blocks.size() - 1);
            blk = held_blocks[idx];
            held_blocks.delete(idx);
            send(ffpa_pkg::ACT_RELEASE, blk.size, blk.addr);
        end
        else if (pick >= 85)
        begin
            if ($urandom_range(3) == 0)
            begin
                send(ffpa_pkg::ACT_ALLOC, '0, ffpa_pkg::ADDR_W'($urandom));
            end
            else
            begin
                sz = ($urandom_range(1) == 0) ? ffpa_pkg::SIZE_W'($urandom_range(31))
                                              : ffpa_pkg::SIZE_W'($urandom);
                send(ffpa_pkg::ACT_RELEASE, sz, ffpa_pkg::ADDR_W'($urandom));
            end
        end
        else
        begin
            // allocate sizes lean small so the table fragments and refills
            pick = $urandom_range(99);
            if (pick < 80)
                sz = ffpa_pkg::SIZE_W'($urandom_range(48, 1));
            else if (pick < 95)
                sz = ffpa_pkg::SIZE_W'($urandom_range(300, 1));
            else
                sz = ffpa_pkg::SIZE_W'($urandom);
            send(ffpa_pkg::ACT_ALLOC, sz, ffpa_pkg::ADDR_W'($urandom));
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero-size allocate leaves the table alone
        send(ffpa_pkg::ACT_ALLOC, '0, '1);
        // nothing is large enough
        send(ffpa_pkg::ACT_ALLOC, '1, '1);
        // take all free memory, entry stays with zero length
        send(ffpa_pkg::ACT_ALLOC, ffpa_pkg::SIZE_W'(MEMORY_SIZE - RESERVED_BASE), '0);
        // release past the last entry, not adjacent: appended
        send(ffpa_pkg::ACT_RELEASE, '1, '1);
        // release below the first start, not touching it: inserted at the front
        send(ffpa_pkg::ACT_RELEASE, '0, '0);
        // scattered one-unit releases fill the table up
        for (int a = 2; a <= 26; a += 2)
            send(ffpa_pkg::ACT_RELEASE, ffpa_pkg::SIZE_W'(1), ffpa_pkg::ADDR_W'(a));
        // no merge possible and no room left
        send(ffpa_pkg::ACT_RELEASE, ffpa_pkg::SIZE_W'(1), ffpa_pkg::ADDR_W'(28));
        // merges with the lower neighbor only, even in a full table
        send(ffpa_pkg::ACT_RELEASE, ffpa_pkg::SIZE_W'(1), ffpa_pkg::ADDR_W'(27));
        // bridges two neighbors, one entry drops out
        send(ffpa_pkg::ACT_RELEASE, ffpa_pkg::SIZE_W'(1), ffpa_pkg::ADDR_W'(3));
        // same start as an inner entry: table unchanged
        send(ffpa_pkg::ACT_RELEASE, ffpa_pkg::SIZE_W'(3), ffpa_pkg::ADDR_W'(20));
        // merges with the higher neighbor only
        send(ffpa_pkg::ACT_RELEASE, ffpa_pkg::SIZE_W'(1), ffpa_pkg::ADDR_W'(999));
        // at the first start with its end touching it: merges downward
        send(ffpa_pkg::ACT_RELEASE, '0, '0);
        // fit found in the entry above the address range, then a grant that wraps
        send(ffpa_pkg::ACT_ALLOC, ffpa_pkg::SIZE_W'(1000), '1);
        send(ffpa_pkg::ACT_ALLOC, ffpa_pkg::SIZE_W'(20), '0);

        // random traffic under three idle mixes
        for (int n = 0; n < PHASE_ITEMS; n++)
            send_random();
        send_gap_pct = 87;
        stall_pct    = 8;
        for (int n = 0; n < PHASE_ITEMS; n++)
            send_random();
        send_gap_pct = 0;
        stall_pct    = 0;
        for (int n = 0; n < PHASE_ITEMS; n++)
            send_random();
        req_valid <= 1'b0;

        // drain outstanding results, then give stray transfers a chance to show
        @(posedge clk);
        while (owed != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("** first_fit_partition_allocator_core: PASSED **");
        else
            $display("** first_fit_partition_allocator_core: FAILED **");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("** first_fit_partition_allocator_core: FAILED **");
        $finish;
    end

endmodule
